@@ rtl/dam_pkg.sv @@
// ----------------------------------------------------------------------------
// DRAM address mapper package
// Shared beat types, configuration layout, register indexes and reset values.
// ----------------------------------------------------------------------------
package dam_pkg;

  localparam int ADDR_W      = 48;   // physical address bits
  localparam int POS_W       = 7;    // bit position inside the address, offset included
  localparam int CO_FULL_W   = 15;   // mode 3 column before the cut to the output field
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 5;

  typedef enum logic [1:0] {
    MODE_CO_FIRST = 2'd0,  // column, row, bank, bank group, rank, channel
    MODE_CH_FIRST = 2'd1,  // channel, column, rank, bank group, bank, row
    MODE_CO_CH    = 2'd2,  // column, channel, bank group, bank, rank, row
    MODE_XOR_HASH = 2'd3   // split column, xor-hashed levels
  } map_mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_MAPPING_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANK_WIDTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BANKGROUP_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_WIDTH      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_WIDTH    = 3'd7;

  localparam logic [3:0] RST_TRANSFER_OFFSET = 4'd6;
  localparam logic [2:0] RST_CHANNEL_WIDTH   = 3'd0;
  localparam logic [1:0] RST_RANK_WIDTH      = 2'd1;
  localparam logic [1:0] RST_BANKGROUP_WIDTH = 2'd2;
  localparam logic [2:0] RST_BANK_WIDTH      = 3'd2;
  localparam logic [4:0] RST_ROW_WIDTH       = 5'd16;
  localparam logic [3:0] RST_COLUMN_WIDTH    = 4'd7;

  typedef struct packed {
    map_mode_t  mapping_mode;
    logic [3:0] transfer_offset;
    logic [2:0] channel_width;
    logic [1:0] rank_width;
    logic [1:0] bankgroup_width;
    logic [2:0] bank_width;
    logic [4:0] row_width;
    logic [3:0] column_width;
  } dam_cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              address_present;
  } in_beat_t;

  typedef struct packed {
    logic        mapped;
    logic [3:0]  channel;
    logic [2:0]  rank;
    logic [2:0]  bankgroup;
    logic [3:0]  bank;
    logic [21:0] row;
    logic [11:0] column;
  } out_beat_t;

endpackage

@@ rtl/dam_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// DRAM address mapper configuration registers
// Holds mode, transfer offset and the level widths, written by index.
// ----------------------------------------------------------------------------
module dam_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dam_pkg::CFG_DATA_W-1:0] cfg_data,
  output dam_pkg::dam_cfg_t              cfg
);
  import dam_pkg::*;

  dam_cfg_t cfg_r;
  dam_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MAPPING_MODE:    cfg_nxt.mapping_mode    = map_mode_t'(cfg_data[1:0]);
        REG_TRANSFER_OFFSET: cfg_nxt.transfer_offset = cfg_data[3:0];
        REG_CHANNEL_WIDTH:   cfg_nxt.channel_width   = cfg_data[2:0];
        REG_RANK_WIDTH:      cfg_nxt.rank_width      = cfg_data[1:0];
        REG_BANKGROUP_WIDTH: cfg_nxt.bankgroup_width = cfg_data[1:0];
        REG_BANK_WIDTH:      cfg_nxt.bank_width      = cfg_data[2:0];
        REG_ROW_WIDTH:       cfg_nxt.row_width       = cfg_data[4:0];
        REG_COLUMN_WIDTH:    cfg_nxt.column_width    = cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mapping_mode    <= MODE_CO_FIRST;
      cfg_r.transfer_offset <= RST_TRANSFER_OFFSET;
      cfg_r.channel_width   <= RST_CHANNEL_WIDTH;
      cfg_r.rank_width      <= RST_RANK_WIDTH;
      cfg_r.bankgroup_width <= RST_BANKGROUP_WIDTH;
      cfg_r.bank_width      <= RST_BANK_WIDTH;
      cfg_r.row_width       <= RST_ROW_WIDTH;
      cfg_r.column_width    <= RST_COLUMN_WIDTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/dam_mapper.sv @@
// ----------------------------------------------------------------------------
// DRAM address mapper core
// Field positions from the mode and widths, one shift per level, xor hash.
// ----------------------------------------------------------------------------
module dam_mapper (
  input  dam_pkg::dam_cfg_t  cfg,
  input  dam_pkg::in_beat_t  in_beat,
  output dam_pkg::out_beat_t out_beat
);
  import dam_pkg::*;

  function automatic logic [ADDR_W-1:0] low_mask(input logic [4:0] n);
    return ~({ADDR_W{1'b1}} << n);
  endfunction

  logic [POS_W-1:0] wc, wr, wg, wb, wo, wl, rest, off;
  logic [POS_W-1:0] p_ch, p_ra, p_bg, p_ba, p_ro, p_co, p_cr;
  logic [POS_W-1:0] q_ra, q_bg, q_ba, q_ro;
  logic [ADDR_W-1:0] sh_ch, sh_ra, sh_bg, sh_ba, sh_ro, sh_co, sh_cr;
  logic [ADDR_W-1:0] m_ch, m_ra, m_bg, m_ba, m_ro, m_co, m_cr;
  logic [ADDR_W-1:0] co_ext;
  logic [ADDR_W-1:0] hx_ch, hx_ra, hx_bg, hx_ba, hx_ro;
  logic [CO_FULL_W-1:0] co_full;
  logic hash;

  assign wc  = POS_W'(cfg.channel_width);
  assign wr  = POS_W'(cfg.rank_width);
  assign wg  = POS_W'(cfg.bankgroup_width);
  assign wb  = POS_W'(cfg.bank_width);
  assign wo  = POS_W'(cfg.row_width);
  assign wl  = POS_W'(cfg.column_width);
  assign off = POS_W'(cfg.transfer_offset);
  // second column slice of mode 3 saturates at zero width
  assign rest = (cfg.column_width >= 4'd2) ? POS_W'(cfg.column_width - 4'd2) : '0;
  assign hash = (cfg.mapping_mode == MODE_XOR_HASH);

  always_comb begin
    p_ch = '0; p_ra = '0; p_bg = '0; p_ba = '0; p_ro = '0; p_co = '0; p_cr = '0;
    unique case (cfg.mapping_mode)
      MODE_CO_FIRST: begin
        p_co = '0;
        p_ro = wl;
        p_ba = p_ro + wo;
        p_bg = p_ba + wb;
        p_ra = p_bg + wg;
        p_ch = p_ra + wr;
      end
      MODE_CH_FIRST: begin
        p_ch = '0;
        p_co = wc;
        p_ra = p_co + wl;
        p_bg = p_ra + wr;
        p_ba = p_bg + wg;
        p_ro = p_ba + wb;
      end
      MODE_CO_CH: begin
        p_co = '0;
        p_ch = wl;
        p_bg = p_ch + wc;
        p_ba = p_bg + wg;
        p_ra = p_ba + wb;
        p_ro = p_ra + wr;
      end
      MODE_XOR_HASH: begin
        p_co = '0;
        p_ch = POS_W'(2);
        p_ra = p_ch + wc;
        p_bg = p_ra + wr;
        p_ba = p_bg + wg;
        p_cr = p_ba + wb;
        p_ro = p_cr + rest;
      end
    endcase
  end

  // bits past the top of the address shift in as zero
  assign sh_ch = in_beat.address >> (p_ch + off);
  assign sh_ra = in_beat.address >> (p_ra + off);
  assign sh_bg = in_beat.address >> (p_bg + off);
  assign sh_ba = in_beat.address >> (p_ba + off);
  assign sh_ro = in_beat.address >> (p_ro + off);
  assign sh_co = in_beat.address >> (p_co + off);
  assign sh_cr = in_beat.address >> (p_cr + off);

  assign m_ch = sh_ch & low_mask(5'(cfg.channel_width));
  assign m_ra = sh_ra & low_mask(5'(cfg.rank_width));
  assign m_bg = sh_bg & low_mask(5'(cfg.bankgroup_width));
  assign m_ba = sh_ba & low_mask(5'(cfg.bank_width));
  assign m_ro = sh_ro & low_mask(cfg.row_width);
  assign m_co = sh_co & low_mask(5'(cfg.column_width));
  assign m_cr = sh_cr & low_mask(5'(rest));

  assign co_full = hash ? {m_cr[CO_FULL_W-3:0], sh_co[1:0]} : m_co[CO_FULL_W-1:0];
  assign co_ext  = ADDR_W'(co_full);

  // successive column slices, one per nonzero level width
  assign q_ra = wc;
  assign q_bg = q_ra + wr;
  assign q_ba = q_bg + wg;
  assign q_ro = q_ba + wb;

  assign hx_ch = co_ext & low_mask(5'(cfg.channel_width));
  assign hx_ra = (co_ext >> q_ra) & low_mask(5'(cfg.rank_width));
  assign hx_bg = (co_ext >> q_bg) & low_mask(5'(cfg.bankgroup_width));
  assign hx_ba = (co_ext >> q_ba) & low_mask(5'(cfg.bank_width));
  assign hx_ro = (co_ext >> q_ro) & low_mask(cfg.row_width);

  always_comb begin
    out_beat = '0;
    if (in_beat.address_present) begin
      out_beat.mapped = 1'b1;
      out_beat.column = co_full[11:0];
      if (hash) begin
        out_beat.channel   = m_ch[3:0] ^ hx_ch[3:0];
        out_beat.rank      = m_ra[2:0] ^ hx_ra[2:0];
        out_beat.bankgroup = m_bg[2:0] ^ hx_bg[2:0];
        out_beat.bank      = m_ba[3:0] ^ hx_ba[3:0];
        // row takes everything left over, not just row_width bits
        out_beat.row       = sh_ro[21:0] ^ hx_ro[21:0];
      end else begin
        out_beat.channel   = m_ch[3:0];
        out_beat.rank      = m_ra[2:0];
        out_beat.bankgroup = m_bg[2:0];
        out_beat.bank      = m_ba[3:0];
        out_beat.row       = m_ro[21:0];
      end
    end
  end

endmodule

@@ rtl/dram_address_mapper.sv @@
// ----------------------------------------------------------------------------
// DRAM address mapper
// An accepted beat goes to the input register, its result to the result
// register, which drives out_*; both carry the stall. Throughput: one beat
// per cycle while out_stall is low; the mapping logic is combinational.
// Reset: synchronous, active low; empties both registers and loads the
// configuration reset values (mode 0, offset 6, widths 0/1/2/2/16/7).
// ----------------------------------------------------------------------------
module dram_address_mapper (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dam_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dam_pkg::out_beat_t             out_data,
  input  logic                           cfg_we,
  input  logic [dam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dam_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dam_pkg::*;

  dam_cfg_t  cfg;
  in_beat_t  s1_data_r, s1_data_nxt;
  logic      s1_valid_r, s1_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t map_beat;
  logic      s2_ready, s1_ready;

  dam_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dam_mapper u_mapper (
    .cfg      (cfg),
    .in_beat  (s1_data_r),
    .out_beat (map_beat)
  );

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_data_nxt   = s1_data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    // advance the result register when it is free or being taken
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
      out_data_nxt  = map_beat;
    end
    if (s1_ready) begin
      s1_valid_nxt = in_valid;
      s1_data_nxt  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_data_r  <= s1_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = !s1_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/dam_checker.sv @@
// ----------------------------------------------------------------------------
// DRAM address mapper port checker
// Watches the top-level ports for stall, empty-result and reset behavior.
// ----------------------------------------------------------------------------
module dam_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input dam_pkg::out_beat_t             out_data
);
  import dam_pkg::*;

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // input side backs up only when the result register is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // an unmapped result carries all-zero fields
  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.mapped |->
      out_data.channel == '0 && out_data.rank == '0 && out_data.bankgroup == '0 &&
      out_data.bank == '0 && out_data.row == '0 && out_data.column == '0)
    else $error("unmapped result with nonzero fields");

  // reset drains the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind dram_address_mapper dam_checker u_dam_checker (.*);
